### hw/rtl/rrts_pkg.sv
// Types, codes and constants shared by the round-robin task scheduler.
package rrts_pkg;

	localparam int NS_PER_US = 1000;
	localparam int ADD_W = 42;

	typedef enum logic [2:0] {
		OP_SPAWN     = 3'd0,
		OP_RESUME    = 3'd1,
		OP_TERMINATE = 3'd2,
		OP_YIELD     = 3'd3,
		OP_SUSPEND   = 3'd4,
		OP_SLEEP     = 3'd5,
		OP_FINISH    = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK            = 3'd0,
		STAT_REFUSED       = 3'd1,
		STAT_NO_SLOT       = 3'd2,
		STAT_NOTHING_READY = 3'd3,
		STAT_BLOCK         = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SS_FREE  = 2'd0,
		SS_RUN   = 2'd1,
		SS_READY = 2'd2,
		SS_SUSP  = 2'd3
	} slot_state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  target_slot;
		logic [31:0] sleep_micros;
		logic [47:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  spawned_slot;
		logic [3:0]  running_slot;
		logic        switched;
		logic [47:0] earliest_wake;
	} out_item_t;

endpackage

### hw/rtl/rrts_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module rrts_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/round_robin_task_scheduler_core.sv
// Top level of the round-robin task scheduler: sequencer, slot state and queue control.
//
//   Channel  | Direction | Handshake                   | Beat
//   item     | in        | item_valid / item_stall     | in_item_t
//   result   | out       | result_valid / result_stall | out_item_t
//
// One item is worked on at a time; one result beat follows each item.
// Time per item is set mainly by the scans over the deadline RAM (one entry a cycle) and by
// the walk of the ready queue when a ready task is terminated.
// Reset makes slot 0 the running task and empties the queue; no clearing pass is needed.
// A new item is taken while the previous result is still stalled on the output register.
module round_robin_task_scheduler_core import rrts_pkg::*; #(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam int SW = $clog2(SLOTS);
	localparam int WB = ((TIME_BITS > ADD_W) ? TIME_BITS : ADD_W) + 1;
	localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DEC    = 10'b0000000010,
		S_SPAWN  = 10'b0000000100,
		S_WAKE   = 10'b0000001000,
		S_POP_RD = 10'b0000010000,
		S_POP_EX = 10'b0000100000,
		S_UL_RD  = 10'b0001000000,
		S_UL_EV  = 10'b0010000000,
		S_EARLY  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;
	slot_state_t st_q [SLOTS];
	logic [SLOTS-1:0] slp_q;
	logic [SW-1:0] head_q, tail_q, cur_q, before_q, spawn_q, walk_q, prev_q, ri_s1;
	logic empty_q, first_q, rv_s1, mz_q, rvalid_q;
	logic [SW:0] idx_q;
	logic [2:0] op_q;
	logic [3:0] tgt_q;
	logic [ADD_W-1:0] add_q;
	logic [TIME_BITS-1:0] now_q, early_q;
	status_t stat_q;
	out_item_t res_q;

	logic l_we, d_we;
	logic [SW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;
	logic [TIME_BITS-1:0] d_rdata, dl_calc;
	logic [WB-1:0] dl_sum;
	logic [SW-1:0] sidx, tsl;
	slot_state_t st_rd;
	logic slp_rd, tgt_range, res_ok, term_ok, any_slp, wake_hit, wake_push;
	logic pe, requeue, scan_last, ul_hit, accept;
	logic [SW-1:0] nh;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign result_valid = rvalid_q;
	assign result = res_q;

	always_comb begin
		priority if (state_q == S_SPAWN) begin
			sidx = idx_q[SW-1:0];
		end else if (state_q == S_DEC) begin
			sidx = SW'(tgt_q);
		end else begin
			sidx = ri_s1;
		end
	end

	assign tsl = SW'(tgt_q);
	assign st_rd = st_q[sidx];
	assign slp_rd = slp_q[sidx];
	assign tgt_range = (32'(tgt_q) < SLOTS);
	assign res_ok = tgt_range && (st_rd == SS_SUSP);
	assign term_ok = tgt_range && (tgt_q != 4'd0) && (tsl != cur_q) && (st_rd != SS_FREE);
	assign any_slp = |slp_q;
	assign wake_hit = rv_s1 && slp_rd && (d_rdata <= now_q);
	assign wake_push = (state_q == S_WAKE) && wake_hit && (st_rd == SS_SUSP);
	assign scan_last = rv_s1 && (ri_s1 == SW'(SLOTS - 1));
	assign pe = (head_q == tail_q);
	assign nh = pe ? head_q : l_rdata;
	assign requeue = (op_q == OP_YIELD) || ((op_q == OP_SLEEP) && mz_q);
	assign ul_hit = (walk_q == tsl);
	assign dl_sum = WB'(now_q) + WB'(add_q);
	assign dl_calc = (dl_sum > WB'(TIME_MASK)) ? TIME_MASK : dl_sum[TIME_BITS-1:0];

	always_comb begin
		l_we = 1'b0;
		l_waddr = tail_q;
		l_wdata = cur_q;
		l_raddr = (state_q == S_UL_RD) ? walk_q : head_q;
		if (wake_push && !empty_q) begin
			l_we = 1'b1;
			l_wdata = ri_s1;
		end else if (state_q == S_DEC && op_q == OP_RESUME && res_ok && !empty_q) begin
			l_we = 1'b1;
			l_wdata = tsl;
		end else if (state_q == S_POP_EX && requeue && !pe) begin
			l_we = 1'b1;
			l_wdata = cur_q;
		end else if (state_q == S_UL_EV && ul_hit && !pe && !first_q && walk_q != tail_q) begin
			l_we = 1'b1;
			l_waddr = prev_q;
			l_wdata = l_rdata;
		end
	end

	assign d_we = (state_q == S_DEC) && (op_q == OP_SLEEP) && !mz_q && !empty_q;

	rrts_ram #(.DEPTH(SLOTS), .WIDTH(SW)) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	rrts_ram #(.DEPTH(SLOTS), .WIDTH(TIME_BITS)) u_deadline_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (cur_q),
		.wdata (dl_calc),
		.raddr (idx_q[SW-1:0]),
		.rdata (d_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i] <= (i == 0) ? SS_RUN : SS_FREE;
			end
			slp_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			cur_q <= '0;
			before_q <= '0;
			spawn_q <= '0;
			walk_q <= '0;
			prev_q <= '0;
			ri_s1 <= '0;
			first_q <= 1'b0;
			rv_s1 <= 1'b0;
			mz_q <= 1'b0;
			rvalid_q <= 1'b0;
			idx_q <= '0;
			op_q <= '0;
			tgt_q <= '0;
			add_q <= '0;
			now_q <= '0;
			early_q <= '0;
			stat_q <= STAT_OK;
			res_q <= '0;
		end else begin
			if (rvalid_q && !result_stall) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= item.operation;
						tgt_q <= item.target_slot;
						mz_q <= (item.sleep_micros == 32'd0);
						add_q <= ADD_W'(item.sleep_micros) * ADD_W'(NS_PER_US);
						now_q <= TIME_BITS'(item.now_time);
						before_q <= cur_q;
						spawn_q <= '0;
						stat_q <= STAT_REFUSED;
						idx_q <= '0;
						early_q <= '0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_EARLY;
					unique case (op_q)
						OP_SPAWN: begin
							state_q <= S_SPAWN;
						end
						OP_RESUME: begin
							if (res_ok) begin
								slp_q[tsl] <= 1'b0;
								st_q[tsl] <= SS_READY;
								if (empty_q) begin
									head_q <= tsl;
								end
								tail_q <= tsl;
								empty_q <= 1'b0;
								stat_q <= STAT_OK;
							end
						end
						OP_TERMINATE: begin
							if (term_ok) begin
								slp_q[tsl] <= 1'b0;
								st_q[tsl] <= SS_FREE;
								stat_q <= STAT_OK;
								if (st_rd == SS_READY && !empty_q) begin
									walk_q <= head_q;
									prev_q <= '0;
									first_q <= 1'b1;
									state_q <= S_UL_RD;
								end
							end
						end
						OP_YIELD: begin
							state_q <= S_WAKE;
						end
						OP_SUSPEND: begin
							if (cur_q == '0 && empty_q && !any_slp) begin
								stat_q <= STAT_REFUSED;
							end else if (!empty_q) begin
								state_q <= S_POP_RD;
							end else begin
								state_q <= S_WAKE;
							end
						end
						OP_SLEEP: begin
							if (mz_q) begin
								state_q <= S_WAKE;
							end else if (!empty_q) begin
								slp_q[cur_q] <= 1'b1;
								state_q <= S_POP_RD;
							end else begin
								stat_q <= STAT_BLOCK;
							end
						end
						OP_FINISH: begin
							if (cur_q != '0) begin
								st_q[cur_q] <= SS_FREE;
								slp_q[cur_q] <= 1'b0;
								if (!empty_q) begin
									state_q <= S_POP_RD;
								end else begin
									slp_q[0] <= 1'b0;
									st_q[0] <= SS_RUN;
									cur_q <= '0;
									stat_q <= STAT_OK;
								end
							end
						end
						default: begin
							stat_q <= STAT_REFUSED;
						end
					endcase
				end
				S_SPAWN: begin
					if (st_rd == SS_FREE) begin
						st_q[sidx] <= SS_SUSP;
						slp_q[sidx] <= 1'b0;
						spawn_q <= sidx;
						stat_q <= STAT_OK;
						idx_q <= '0;
						state_q <= S_EARLY;
					end else if (sidx == SW'(SLOTS - 1)) begin
						stat_q <= STAT_NO_SLOT;
						idx_q <= '0;
						state_q <= S_EARLY;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WAKE, S_EARLY: begin
					if (idx_q < (SW + 1)'(SLOTS)) begin
						rv_s1 <= 1'b1;
						ri_s1 <= idx_q[SW-1:0];
						idx_q <= idx_q + 1'b1;
					end else begin
						rv_s1 <= 1'b0;
					end
					if (state_q == S_WAKE) begin
						if (wake_hit) begin
							slp_q[ri_s1] <= 1'b0;
						end
						if (wake_push) begin
							st_q[ri_s1] <= SS_READY;
							if (empty_q) begin
								head_q <= ri_s1;
							end
							tail_q <= ri_s1;
							empty_q <= 1'b0;
						end
						if (scan_last) begin
							state_q <= S_POP_RD;
						end
					end else begin
						if (rv_s1 && slp_rd && (early_q == '0 || d_rdata < early_q)) begin
							early_q <= d_rdata;
						end
						if (scan_last) begin
							state_q <= S_DONE;
						end
					end
				end
				S_POP_RD: begin
					if (empty_q) begin
						if (op_q == OP_SUSPEND) begin
							stat_q <= any_slp ? STAT_BLOCK : STAT_NOTHING_READY;
						end else begin
							stat_q <= STAT_NOTHING_READY;
						end
						idx_q <= '0;
						early_q <= '0;
						state_q <= S_EARLY;
					end else begin
						state_q <= S_POP_EX;
					end
				end
				S_POP_EX: begin
					if (requeue) begin
						st_q[cur_q] <= SS_READY;
						head_q <= pe ? cur_q : nh;
						tail_q <= cur_q;
						empty_q <= 1'b0;
					end else begin
						if (op_q != OP_FINISH) begin
							st_q[cur_q] <= SS_SUSP;
						end
						head_q <= nh;
						empty_q <= pe;
					end
					st_q[head_q] <= SS_RUN;
					cur_q <= head_q;
					stat_q <= STAT_OK;
					idx_q <= '0;
					early_q <= '0;
					state_q <= S_EARLY;
				end
				S_UL_RD: begin
					state_q <= S_UL_EV;
				end
				S_UL_EV: begin
					if (ul_hit) begin
						if (pe) begin
							empty_q <= 1'b1;
						end else if (first_q) begin
							head_q <= l_rdata;
						end else if (walk_q == tail_q) begin
							tail_q <= prev_q;
						end
						idx_q <= '0;
						state_q <= S_EARLY;
					end else if (walk_q == tail_q || idx_q == (SW + 1)'(SLOTS - 1)) begin
						idx_q <= '0;
						state_q <= S_EARLY;
					end else begin
						prev_q <= walk_q;
						walk_q <= l_rdata;
						first_q <= 1'b0;
						idx_q <= idx_q + 1'b1;
						state_q <= S_UL_RD;
					end
				end
				S_DONE: begin
					if (!rvalid_q || !result_stall) begin
						res_q.status <= stat_q;
						res_q.spawned_slot <= 4'(spawn_q);
						res_q.running_slot <= 4'(cur_q);
						res_q.switched <= (cur_q != before_q);
						res_q.earliest_wake <= 48'(early_q);
						rvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cur_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> st_q[cur_q] == SS_RUN)
		else $error("running slot is not marked running");

	a_cur_awake: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !slp_q[cur_q])
		else $error("running slot is marked sleeping");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rvalid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");
`endif

endmodule

### verif/tb_round_robin_task_scheduler_core.sv
// Testbench for the round-robin task scheduler core: directed and random items and a predictor.
`timescale 1ns / 100ps

module tb_round_robin_task_scheduler_core;
	import rrts_pkg::*;

	localparam logic [2:0] OP_UNDEFINED = 3'd7;
	localparam int SLOT_COUNT = 16;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	logic [47:0] clock_ns = '0;

	out_item_t pending_results[$];

	slot_state_t slot_state[SLOT_COUNT];
	logic [3:0] ready_link[SLOT_COUNT];
	logic [3:0] ready_head;
	logic [3:0] ready_tail;
	bit ready_empty;
	logic [3:0] running;
	bit asleep[SLOT_COUNT];
	logic [47:0] wake_at[SLOT_COUNT];

	round_robin_task_scheduler_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #2 clk = ~clk;

	function automatic void sched_reset();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_state[i] = SS_FREE;
			ready_link[i] = '0;
			asleep[i] = 1'b0;
			wake_at[i] = '0;
		end
		slot_state[0] = SS_RUN;
		ready_head = '0;
		ready_tail = '0;
		ready_empty = 1'b1;
		running = '0;
	endfunction

	function automatic void ready_push(logic [3:0] s);
		ready_link[s] = s;
		if (ready_empty) begin
			ready_head = s;
		end else begin
			ready_link[ready_tail] = s;
		end
		ready_tail = s;
		ready_empty = 1'b0;
	endfunction

	function automatic bit ready_pop(output logic [3:0] s);
		s = '0;
		if (ready_empty) begin
			return 1'b0;
		end
		s = ready_head;
		if (ready_head == ready_tail) begin
			ready_empty = 1'b1;
		end else begin
			ready_head = ready_link[ready_head];
		end
		return 1'b1;
	endfunction

	function automatic void ready_remove(logic [3:0] s);
		logic [3:0] prev;
		logic [3:0] walk;
		bit first;
		prev = '0;
		walk = ready_head;
		first = 1'b1;
		if (ready_empty) begin
			return;
		end
		for (int n = 0; n < SLOT_COUNT; n++) begin
			if (walk == s) begin
				if (ready_head == ready_tail) begin
					ready_empty = 1'b1;
				end else if (first) begin
					ready_head = ready_link[walk];
				end else if (walk == ready_tail) begin
					ready_tail = prev;
				end else begin
					ready_link[prev] = ready_link[walk];
				end
				return;
			end
			if (walk == ready_tail) begin
				return;
			end
			prev = walk;
			walk = ready_link[walk];
			first = 1'b0;
		end
	endfunction

	function automatic bit anyone_asleep();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (asleep[i]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void wake_sleepers(logic [47:0] now);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (asleep[i] && wake_at[i] <= now) begin
				asleep[i] = 1'b0;
				if (slot_state[i] == SS_SUSP) begin
					slot_state[i] = SS_READY;
					ready_push(4'(i));
				end
			end
		end
	endfunction

	function automatic logic [47:0] first_deadline();
		logic [47:0] e;
		e = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (asleep[i] && (e == 0 || wake_at[i] < e)) begin
				e = wake_at[i];
			end
		end
		return e;
	endfunction

	function automatic void hand_over(logic [3:0] nxt, bit requeue);
		if (requeue) begin
			slot_state[running] = SS_READY;
			ready_push(running);
		end else begin
			slot_state[running] = SS_SUSP;
		end
		slot_state[nxt] = SS_RUN;
		running = nxt;
	endfunction

	function automatic status_t yield_running(logic [47:0] now);
		logic [3:0] nxt;
		wake_sleepers(now);
		if (!ready_pop(nxt)) begin
			return STAT_NOTHING_READY;
		end
		hand_over(nxt, 1'b1);
		return STAT_OK;
	endfunction

	function automatic out_item_t schedule_item(in_item_t it);
		out_item_t r;
		logic [3:0] prior;
		logic [3:0] nxt;
		logic [3:0] tgt;
		logic [63:0] span;
		logic [47:0] due;
		status_t st;
		prior = running;
		tgt = it.target_slot;
		st = STAT_REFUSED;
		r = '0;
		case (it.operation)
			OP_SPAWN: begin
				st = STAT_NO_SLOT;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_state[i] == SS_FREE) begin
						slot_state[i] = SS_SUSP;
						asleep[i] = 1'b0;
						r.spawned_slot = 4'(i);
						st = STAT_OK;
						break;
					end
				end
			end
			OP_RESUME: begin
				if (slot_state[tgt] == SS_SUSP) begin
					asleep[tgt] = 1'b0;
					slot_state[tgt] = SS_READY;
					ready_push(tgt);
					st = STAT_OK;
				end
			end
			OP_TERMINATE: begin
				if (tgt != 0 && tgt != running && slot_state[tgt] != SS_FREE) begin
					asleep[tgt] = 1'b0;
					if (slot_state[tgt] == SS_READY) begin
						ready_remove(tgt);
					end
					slot_state[tgt] = SS_FREE;
					st = STAT_OK;
				end
			end
			OP_YIELD: st = yield_running(it.now_time);
			OP_SUSPEND: begin
				if (running == 0 && ready_empty && !anyone_asleep()) begin
					st = STAT_REFUSED;
				end else if (ready_pop(nxt)) begin
					hand_over(nxt, 1'b0);
					st = STAT_OK;
				end else begin
					wake_sleepers(it.now_time);
					if (ready_pop(nxt)) begin
						hand_over(nxt, 1'b0);
						st = STAT_OK;
					end else begin
						st = anyone_asleep() ? STAT_BLOCK : STAT_NOTHING_READY;
					end
				end
			end
			OP_SLEEP: begin
				if (it.sleep_micros == 0) begin
					st = yield_running(it.now_time);
				end else begin
					span = 64'(it.sleep_micros) * 64'(NS_PER_US);
					if (64'(it.now_time) > 64'(TIME_MAX) - span) begin
						due = TIME_MAX;
					end else begin
						due = it.now_time + span[47:0];
					end
					if (ready_pop(nxt)) begin
						asleep[running] = 1'b1;
						wake_at[running] = due;
						hand_over(nxt, 1'b0);
						st = STAT_OK;
					end else begin
						st = STAT_BLOCK;
					end
				end
			end
			OP_FINISH: begin
				if (running != 0) begin
					slot_state[running] = SS_FREE;
					asleep[running] = 1'b0;
					if (!ready_pop(nxt)) begin
						nxt = '0;
						asleep[0] = 1'b0;
					end
					slot_state[nxt] = SS_RUN;
					running = nxt;
					st = STAT_OK;
				end
			end
			default: st = STAT_REFUSED;
		endcase
		r.status = st;
		r.running_slot = running;
		r.switched = (running != prior);
		r.earliest_wake = first_deadline();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", result, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.spawned_slot !== want.spawned_slot)
					report_mismatch("spawned_slot", result.spawned_slot, want.spawned_slot);
				if (result.running_slot !== want.running_slot)
					report_mismatch("running_slot", result.running_slot, want.running_slot);
				if (result.switched !== want.switched)
					report_mismatch("switched", result.switched, want.switched);
				if (result.earliest_wake !== want.earliest_wake)
					report_mismatch("earliest_wake", result.earliest_wake, want.earliest_wake);
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("** round_robin_task_scheduler_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(schedule_item(it));
	endtask

	task automatic send_op(logic [2:0] op, logic [3:0] tgt, logic [31:0] micros,
			logic [47:0] now);
		in_item_t it;
		it.operation = op;
		it.target_slot = tgt;
		it.sleep_micros = micros;
		it.now_time = now;
		send_item(it);
	endtask

	task automatic wait_for_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_refusals_at_reset();
		send_op(OP_SUSPEND, 4'd0, 32'd0, 48'd0);
		send_op(OP_SLEEP, 4'd0, 32'd5, 48'd100);
		send_op(OP_FINISH, 4'd0, 32'd0, 48'd200);
		send_op(OP_UNDEFINED, 4'd15, 32'hFFFF_FFFF, TIME_MAX);
	endtask

	task automatic test_spawn_limit();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			send_op(OP_SPAWN, 4'(i), 32'd0, 48'd300);
		end
	endtask

	task automatic test_resume_terminate();
		send_op(OP_RESUME, 4'd1, 32'd0, 48'd400);
		send_op(OP_RESUME, 4'd2, 32'd0, 48'd400);
		send_op(OP_RESUME, 4'd3, 32'd0, 48'd400);
		send_op(OP_TERMINATE, 4'd2, 32'd0, 48'd400);
		send_op(OP_TERMINATE, 4'd0, 32'd0, 48'd400);
	endtask

	task automatic test_switching();
		send_op(OP_SLEEP, 4'd0, 32'hFFFF_FFFF, TIME_MAX - 48'd7);
		send_op(OP_SUSPEND, 4'd0, 32'd0, 48'd500);
		send_op(OP_FINISH, 4'd0, 32'd0, 48'd600);
		send_op(OP_YIELD, 4'd0, 32'd0, 48'd700);
	endtask

	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 17) it.operation = OP_SPAWN;
		else if (pick < 33) it.operation = OP_RESUME;
		else if (pick < 43) it.operation = OP_TERMINATE;
		else if (pick < 60) it.operation = OP_YIELD;
		else if (pick < 72) it.operation = OP_SUSPEND;
		else if (pick < 89) it.operation = OP_SLEEP;
		else if (pick < 97) it.operation = OP_FINISH;
		else it.operation = OP_UNDEFINED;
		it.target_slot = 4'($urandom_range(15));
		pick = $urandom_range(7);
		if (pick == 0) it.sleep_micros = '0;
		else if (pick < 6) it.sleep_micros = $urandom_range(60, 1);
		else if (pick == 6) it.sleep_micros = $urandom_range(100000, 1);
		else it.sleep_micros = $urandom;
		pick = $urandom_range(99);
		if (pick == 0) clock_ns = 48'({$urandom, $urandom});
		else if (pick == 1) clock_ns = TIME_MAX - 48'($urandom_range(100000));
		else clock_ns = clock_ns + 48'($urandom_range(30000));
		it.now_time = clock_ns;
		return it;
	endfunction

	task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			send_item(random_item());
		end
	endtask

	initial begin
		sched_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_refusals_at_reset();
		test_spawn_limit();
		test_resume_terminate();
		test_switching();
		test_random_traffic(650, 12, 76);
		wait_for_results();
		test_random_traffic(650, 76, 12);
		test_random_traffic(600, 0, 0);
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** round_robin_task_scheduler_core: PASSED **");
		end else begin
			$display("** round_robin_task_scheduler_core: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/round_robin_task_scheduler_core.sv
verif/tb_round_robin_task_scheduler_core.sv
